@@ rtl/core/i2cmts_pkg.sv @@
// Shared types and codes for the I2C master transaction sequencer.
package i2cmts_pkg;

  // Request kinds carried on the input channel.
  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_EVENT = 2'd1,
    REQ_SHUTDOWN = 2'd2,
    REQ_INIT = 2'd3
  } req_kind_t;

  // Sequencer phase and reported status share one code space.
  typedef enum logic [2:0] {
    ST_DISABLED = 3'd0,
    ST_READY = 3'd1,
    ST_ACTIVE = 3'd2,
    ST_BAD_LENGTH = 3'd3,
    ST_BAD_STATE = 3'd4,
    ST_NOT_ACK = 3'd5,
    ST_ARB_LOST = 3'd6,
    ST_UNEXPECTED = 3'd7
  } status_t;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_RATE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOTIFY_MASK = 1'd1;

  // Bus status codes, upper five bits of the status register.
  localparam int unsigned SC_W = 5;
  localparam logic [SC_W-1:0] SC_START = 5'h01;  // 0x08
  localparam logic [SC_W-1:0] SC_RESTART = 5'h02;  // 0x10
  localparam logic [SC_W-1:0] SC_SLAW_ACK = 5'h03;  // 0x18
  localparam logic [SC_W-1:0] SC_SLAW_NACK = 5'h04;  // 0x20
  localparam logic [SC_W-1:0] SC_DATA_ACK = 5'h05;  // 0x28
  localparam logic [SC_W-1:0] SC_DATA_NACK = 5'h06;  // 0x30
  localparam logic [SC_W-1:0] SC_ARB_LOST = 5'h07;  // 0x38
  localparam logic [SC_W-1:0] SC_SLAR_ACK = 5'h08;  // 0x40
  localparam logic [SC_W-1:0] SC_SLAR_NACK = 5'h09;  // 0x48
  localparam logic [SC_W-1:0] SC_RDATA_ACK = 5'h0a;  // 0x50
  localparam logic [SC_W-1:0] SC_RDATA_NACK = 5'h0b;  // 0x58

  // One registered request.
  typedef struct packed {
    req_kind_t kind;
    logic [6:0] slave_addr;
    logic [7:0] n_out;
    logic [7:0] n_in;
    logic [SC_W-1:0] sc;
    logic [7:0] tx_byte;
    logic [7:0] rx_byte;
  } req_t;

  // Transaction context kept between requests.
  typedef struct packed {
    status_t phase;
    logic [6:0] target_addr;
    logic [7:0] write_left;
    logic [7:0] read_left;
  } seq_state_t;

  // One result before the notify mask is applied.
  typedef struct packed {
    logic tx_data_valid;
    logic [7:0] tx_data;
    logic tx_from_buffer;
    logic ctrl_valid;
    logic ctrl_start;
    logic ctrl_stop;
    logic ctrl_ack;
    logic ctrl_enable;
    logic rx_valid;
    logic [7:0] rx_data;
    status_t status;
    logic ended;
  } result_t;

endpackage

@@ rtl/core/i2cmts_step.sv @@
// Per-request decode: next transaction context and the result fields.
module i2cmts_step
  import i2cmts_pkg::*;
(
  input  req_t       req_i,
  input  seq_state_t state_i,
  output seq_state_t state_nxt,
  output result_t    result_o
);

  logic [7:0] write_dec;
  logic [7:0] read_dec;
  logic       write_done;
  logic       read_done;
  logic       empty_req;
  logic [7:0] slaw;
  logic [7:0] slar;

  assign write_dec  = state_i.write_left - 8'd1;
  assign read_dec   = state_i.read_left - 8'd1;
  assign write_done = (write_dec == 8'd0);
  assign read_done  = (read_dec == 8'd0);
  assign empty_req  = (req_i.n_out == 8'd0) && (req_i.n_in == 8'd0);
  assign slaw       = {state_i.target_addr, 1'b0};
  assign slar       = {state_i.target_addr, 1'b1};

  // Next context.
  always_comb begin
    state_nxt = state_i;
    unique case (req_i.kind)
      REQ_START: begin
        if (!empty_req && state_i.phase == ST_READY) begin
          state_nxt.phase       = ST_ACTIVE;
          state_nxt.target_addr = req_i.slave_addr;
          state_nxt.write_left  = req_i.n_out;
          state_nxt.read_left   = req_i.n_in;
        end
      end
      REQ_EVENT: begin
        if (state_i.phase == ST_ACTIVE) begin
          unique case (req_i.sc)
            SC_START, SC_RESTART, SC_SLAW_ACK, SC_SLAR_ACK: begin
              state_nxt = state_i;
            end
            SC_DATA_ACK: begin
              if (!write_done) begin
                state_nxt.write_left = write_dec;
              end else if (state_i.read_left == 8'd0) begin
                state_nxt.phase = ST_READY;
              end
            end
            SC_DATA_NACK: begin
              if (!write_done) begin
                state_nxt.phase = ST_NOT_ACK;
              end else if (state_i.read_left == 8'd0) begin
                state_nxt.phase = ST_READY;
              end
            end
            SC_RDATA_ACK, SC_RDATA_NACK: begin
              if (read_done) begin
                state_nxt.phase = ST_READY;
              end else begin
                state_nxt.read_left = read_dec;
              end
            end
            SC_SLAW_NACK, SC_SLAR_NACK: state_nxt.phase = ST_NOT_ACK;
            SC_ARB_LOST:                state_nxt.phase = ST_ARB_LOST;
            default:                    state_nxt.phase = ST_UNEXPECTED;
          endcase
        end
      end
      REQ_SHUTDOWN: state_nxt.phase = ST_DISABLED;
      REQ_INIT:     state_nxt.phase = ST_READY;
      default:      state_nxt = state_i;
    endcase
  end

  // Result fields.
  always_comb begin
    result_o        = '0;
    result_o.status = state_nxt.phase;
    unique case (req_i.kind)
      REQ_START: begin
        priority if (empty_req) begin
          result_o.status = ST_BAD_LENGTH;
        end else if (state_i.phase >= ST_NOT_ACK) begin
          result_o.status = state_i.phase;
        end else if (state_i.phase != ST_READY) begin
          result_o.status = ST_BAD_STATE;
        end else begin
          result_o.ctrl_valid  = 1'b1;
          result_o.ctrl_start  = 1'b1;
          result_o.ctrl_enable = 1'b1;
        end
      end
      REQ_EVENT: begin
        if (state_i.phase == ST_ACTIVE) begin
          result_o.ctrl_valid = 1'b1;
          unique case (req_i.sc)
            SC_START: begin
              result_o.tx_data_valid = 1'b1;
              result_o.tx_data       = (state_i.write_left != 8'd0) ? slaw : slar;
              result_o.ctrl_enable   = 1'b1;
            end
            SC_RESTART: begin
              result_o.tx_data_valid = 1'b1;
              result_o.tx_data       = slar;
              result_o.ctrl_enable   = 1'b1;
            end
            SC_SLAW_ACK: begin
              result_o.tx_data_valid  = 1'b1;
              result_o.tx_data        = req_i.tx_byte;
              result_o.tx_from_buffer = 1'b1;
              result_o.ctrl_enable    = 1'b1;
            end
            SC_DATA_ACK, SC_DATA_NACK: begin
              // A refused final byte counts as accepted.
              priority if (!write_done && req_i.sc == SC_DATA_NACK) begin
                result_o.ended = 1'b1;
              end else if (!write_done) begin
                result_o.tx_data_valid  = 1'b1;
                result_o.tx_data        = req_i.tx_byte;
                result_o.tx_from_buffer = 1'b1;
                result_o.ctrl_enable    = 1'b1;
              end else if (state_i.read_left == 8'd0) begin
                result_o.ctrl_stop = 1'b1;
                result_o.ended     = 1'b1;
              end else begin
                result_o.ctrl_start  = 1'b1;
                result_o.ctrl_enable = 1'b1;
              end
            end
            SC_SLAR_ACK: begin
              result_o.ctrl_ack    = (state_i.read_left != 8'd1);
              result_o.ctrl_enable = 1'b1;
            end
            SC_RDATA_ACK, SC_RDATA_NACK: begin
              result_o.rx_valid = 1'b1;
              result_o.rx_data  = req_i.rx_byte;
              if (read_done) begin
                result_o.ctrl_stop = 1'b1;
                result_o.ended     = 1'b1;
              end else begin
                result_o.ctrl_ack    = (read_dec != 8'd1);
                result_o.ctrl_enable = 1'b1;
              end
            end
            default: begin
              // Not-ack, arbitration loss and unknown codes release the unit.
              result_o.ended = 1'b1;
            end
          endcase
        end
      end
      REQ_SHUTDOWN: result_o.ctrl_valid = 1'b1;
      REQ_INIT:     result_o.ctrl_valid = 1'b0;
      default:      result_o.ctrl_valid = 1'b0;
    endcase
  end

endmodule

@@ rtl/core/i2c_master_transaction_sequencer.sv @@
// Top level of the I2C master transaction sequencer: request and result stages.
// A request is first held in the request stage; its result is then registered in the result stage.
// Throughput: one request per cycle; both stages advance together whenever the
//   result register is empty or its result is taken in the same cycle.
// Reset (rst_n low, synchronous): both stages empty, phase disabled, counters,
//   target address and both configuration registers cleared.
module i2c_master_transaction_sequencer
  import i2cmts_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // Configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_wdata,
  // Request channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_req_type,
  input  logic [6:0]           in_slave_addr,
  input  logic [7:0]           in_n_out,
  input  logic [7:0]           in_n_in,
  input  logic [7:0]           in_bus_status,
  input  logic [7:0]           in_tx_byte,
  input  logic [7:0]           in_rx_byte,
  // Result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_tx_data_valid,
  output logic [7:0]           out_tx_data,
  output logic                 out_tx_from_buffer,
  output logic                 out_ctrl_valid,
  output logic                 out_ctrl_start,
  output logic                 out_ctrl_stop,
  output logic                 out_ctrl_ack,
  output logic                 out_ctrl_enable,
  output logic                 out_rx_valid,
  output logic [7:0]           out_rx_data,
  output logic [2:0]           out_status,
  output logic [7:0]           out_notify
);

  // Configuration registers: bit rate and notify mask.
  logic [7:0] bit_rate_r;
  logic [7:0] notify_mask_r;

  // Request stage.
  logic req_valid_r;
  req_t req_r;

  // Transaction context.
  seq_state_t state_r;
  seq_state_t state_nxt;

  // Result stage.
  logic       res_valid_r;
  result_t    res_r;
  logic [7:0] notify_r;
  result_t    step_res;

  logic advance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_rate_r    <= '0;
      notify_mask_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BIT_RATE:    bit_rate_r    <= cfg_wdata;
        CFG_NOTIFY_MASK: notify_mask_r <= cfg_wdata;
        default:         bit_rate_r    <= bit_rate_r;
      endcase
    end
  end

  // Advance both stages when the result register can take a new result.
  assign advance  = !res_valid_r || out_ready;
  assign in_ready = !req_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_ready) begin
      req_valid_r <= in_valid;
    end
  end

  // Hold the request payload; keep only the decoded bits of the bus status.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r <= '0;
    end else if (in_valid && in_ready) begin
      req_r.kind       <= req_kind_t'(in_req_type);
      req_r.slave_addr <= in_slave_addr;
      req_r.n_out      <= in_n_out;
      req_r.n_in       <= in_n_in;
      req_r.sc         <= in_bus_status[7:8-SC_W];
      req_r.tx_byte    <= in_tx_byte;
      req_r.rx_byte    <= in_rx_byte;
    end
  end

  i2cmts_step u_step (
    .req_i     (req_r),
    .state_i   (state_r),
    .state_nxt (state_nxt),
    .result_o  (step_res)
  );

  // Commit the context only when the request moves into the result stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase       <= ST_DISABLED;
      state_r.target_addr <= '0;
      state_r.write_left  <= '0;
      state_r.read_left   <= '0;
    end else if (req_valid_r && advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (advance) begin
      res_valid_r <= req_valid_r;
    end
  end

  // Raise the notify mask on the result that ends a transaction.
  always_ff @(posedge clk) begin
    if (req_valid_r && advance) begin
      res_r    <= step_res;
      notify_r <= step_res.ended ? notify_mask_r : 8'd0;
    end
  end

  assign out_valid          = res_valid_r;
  assign out_tx_data_valid  = res_r.tx_data_valid;
  assign out_tx_data        = res_r.tx_data;
  assign out_tx_from_buffer = res_r.tx_from_buffer;
  assign out_ctrl_valid     = res_r.ctrl_valid;
  assign out_ctrl_start     = res_r.ctrl_start;
  assign out_ctrl_stop      = res_r.ctrl_stop;
  assign out_ctrl_ack       = res_r.ctrl_ack;
  assign out_ctrl_enable    = res_r.ctrl_enable;
  assign out_rx_valid       = res_r.rx_valid;
  assign out_rx_data        = res_r.rx_data;
  assign out_status         = res_r.status;
  assign out_notify         = notify_r;

`ifndef ASSERT_OFF
  // A transaction never ends without a control command.
  a_end_has_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && res_r.ended |-> res_r.ctrl_valid)
    else $error("transaction ended without a control command");

  // A stop always releases the unit and leaves the sequencer ready.
  a_stop_releases: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && res_r.ctrl_stop |-> !res_r.ctrl_enable && res_r.status == ST_READY)
    else $error("stop issued with unit enabled or sequencer not ready");

  // Request-only status codes never become the phase.
  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.phase != ST_BAD_LENGTH && state_r.phase != ST_BAD_STATE)
    else $error("phase holds a request-only status code");

  // Received bytes are only delivered while or as a read completes.
  a_rx_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && res_r.rx_valid |-> res_r.status == ST_ACTIVE || res_r.status == ST_READY)
    else $error("received byte outside an active read");

  // An accepted request always lands in the request stage.
  a_req_captured: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> req_valid_r)
    else $error("accepted request lost");
`endif

endmodule
